FILE: hdl/hbef_pkg.sv
package hbef_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DISP_W        = 32;
   localparam int PAR_W         = 32;
   localparam int ACC_W         = 48;
   localparam int ENERGY_W      = 64;
   localparam int SUMSQ_W       = 66;
   localparam int ROOT_W        = 33;
   localparam int NUM_W         = 130;
   localparam int LANES         = 3;
   localparam int DEN_W         = ROOT_W + 24;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      logic zero;
      logic eneg;
   } lane_ctl_type;

endpackage

FILE: hdl/hbef_isqrt.sv
// Pipelined integer square root: one result bit per stage.
module hbef_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [hbef_pkg::SUMSQ_W-1:0] radicand,
   output logic                        out_valid,
   output logic [hbef_pkg::ROOT_W-1:0] root
);
   import hbef_pkg::*;

   localparam int STAGES = ROOT_W;

   logic [SUMSQ_W-1:0] rem_ff  [STAGES+1];
   logic [ROOT_W-1:0]  res_ff  [STAGES+1];
   logic [SUMSQ_W-1:0] rad_ff  [STAGES+1];
   logic               vld_ff  [STAGES+1];

   always_comb begin
      rem_ff[0] = '0;
      res_ff[0] = '0;
      rad_ff[0] = radicand;
      vld_ff[0] = in_valid;
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [SUMSQ_W+1:0] rem_in;
      logic [SUMSQ_W+1:0] trial_in;
      always_comb begin
         rem_in   = {rem_ff[s], rad_ff[s][SUMSQ_W-1 -: 2]};
         trial_in = {{(SUMSQ_W-ROOT_W){1'b0}}, res_ff[s], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (reset) vld_ff[s+1] <= 1'b0;
         else       vld_ff[s+1] <= vld_ff[s];
         rad_ff[s+1] <= {rad_ff[s][SUMSQ_W-3:0], 2'b00};
         if (rem_in >= trial_in) begin
            rem_ff[s+1] <= SUMSQ_W'(rem_in - trial_in);
            res_ff[s+1] <= {res_ff[s][ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= SUMSQ_W'(rem_in);
            res_ff[s+1] <= {res_ff[s][ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign out_valid = vld_ff[STAGES];
   assign root      = res_ff[STAGES];
endmodule

FILE: hdl/hbef_lane.sv
// One force component: restoring divide, one quotient bit per stage.
module hbef_lane (
   input  logic                          clock,
   input  logic [hbef_pkg::NUM_W-1:0]    numer,
   input  logic [hbef_pkg::DEN_W-1:0]    denom,
   input  logic                          sign_neg,
   input  hbef_pkg::lane_ctl_type        ctl,
   input  hbef_pkg::acc_type             acc_in,
   output hbef_pkg::acc_type             acc_out,
   output logic                          sat
);
   import hbef_pkg::*;

   localparam int QW = ACC_W + 1;          // quotient bits kept
   localparam int HW = NUM_W - QW;         // high part checked for overflow
   localparam int RW = DEN_W + 1;

   // High quotient bits are nonzero exactly when numer_hi >= denom.
   logic [RW-1:0]    rem_ff  [QW+1];
   logic [QW-1:0]    q_ff    [QW+1];
   logic [QW-1:0]    lo_ff   [QW+1];
   logic             ovf_ff  [QW+1];
   logic [DEN_W-1:0] den_ff  [QW+1];
   logic             neg_ff  [QW+1];
   lane_ctl_type     ctl_ff  [QW+1];
   acc_type          acc_ff  [QW+1];

   logic ovf0;
   always_comb begin
      ovf0 = numer[NUM_W-1:QW] >= HW'(denom);
   end

   // Stage 0 holds the registered remainder from the high part.
   always_ff @(posedge clock) begin
      ovf_ff[0] <= ovf0;
      rem_ff[0] <= ovf0 ? '0 : RW'(numer[NUM_W-1:QW]);
      lo_ff[0]  <= numer[QW-1:0];
      q_ff[0]   <= '0;
      den_ff[0] <= denom;
      neg_ff[0] <= sign_neg;
      ctl_ff[0] <= ctl;
      acc_ff[0] <= acc_in;
   end

   for (genvar s = 0; s < QW; s++) begin : g_div
      logic [RW:0] sh_in;
      always_comb sh_in = {rem_ff[s], lo_ff[s][QW-1]};
      always_ff @(posedge clock) begin
         lo_ff[s+1]  <= {lo_ff[s][QW-2:0], 1'b0};
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         ctl_ff[s+1] <= ctl_ff[s];
         acc_ff[s+1] <= acc_ff[s];
         ovf_ff[s+1] <= ovf_ff[s];
         if (sh_in >= {2'b00, den_ff[s]}) begin
            rem_ff[s+1] <= RW'(sh_in - {2'b00, den_ff[s]});
            q_ff[s+1]   <= {q_ff[s][QW-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= RW'(sh_in);
            q_ff[s+1]   <= {q_ff[s][QW-2:0], 1'b0};
         end
      end
   end

   localparam logic [QW-1:0] QLIM = QW'(1) << ACC_W;
   logic [QW-1:0]        q;
   logic signed [ACC_W+1:0] sum;
   localparam logic signed [ACC_W+1:0] MAXV = (ACC_W+2)'((64'(1) << (ACC_W-1)) - 1);
   localparam logic signed [ACC_W+1:0] MINV = -MAXV - 1;

   always_comb begin
      q = (ovf_ff[QW] || q_ff[QW] > QLIM) ? QLIM : q_ff[QW];
      if (neg_ff[QW])
         sum = (ACC_W+2)'(acc_ff[QW]) - $signed({1'b0, q});
      else
         sum = (ACC_W+2)'(acc_ff[QW]) + $signed({1'b0, q});
      sat = 1'b0;
      if (ctl_ff[QW].zero) begin
         acc_out = acc_ff[QW];
      end else if (sum > MAXV) begin
         acc_out = MAXV[ACC_W-1:0];
         sat = 1'b1;
      end else if (sum < MINV) begin
         acc_out = MINV[ACC_W-1:0];
         sat = 1'b1;
      end else begin
         acc_out = sum[ACC_W-1:0];
      end
   end
endmodule

FILE: hdl/harmonic_bond_energy_force_core.sv
// Harmonic bond energy and force. Takes one bond per clock (start may be high
// every cycle; busy is always low) and gives its result with rsp_valid after
// the pipeline: two input stages, a radicand register, 33 square-root stages,
// four stages for the deviation and the split products, the entry register and
// divide stages in the three force lanes and the output register. Results leave
// in order, one per cycle, and the receiver cannot stall them.
module harmonic_bond_energy_force_core #(
   parameter int FRAC_BITS = hbef_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic signed [31:0]    req_disp_x,
   input  logic signed [31:0]    req_disp_y,
   input  logic signed [31:0]    req_disp_z,
   input  logic [31:0]           req_force_constant,
   input  logic [31:0]           req_rest_length,
   input  logic signed [47:0]    req_acc_in_x,
   input  logic signed [47:0]    req_acc_in_y,
   input  logic signed [47:0]    req_acc_in_z,
   output logic                  rsp_valid,
   output logic [63:0]           rsp_energy,
   output logic signed [47:0]    rsp_acc_out_x,
   output logic signed [47:0]    rsp_acc_out_y,
   output logic signed [47:0]    rsp_acc_out_z,
   output logic                  rsp_zero_norm,
   output logic                  rsp_saturated
);
   import hbef_pkg::*;

   localparam int SQ = ROOT_W;
   localparam int QW = ACC_W + 1;
   localparam int DLY_ENERGY = QW + 1; // lane depth: entry register and divide stages

   assign busy = 1'b0;

   // Stage A: squares of magnitudes.
   logic [31:0] mag_in [LANES];
   logic [31:0] mag_ff [LANES];
   logic [63:0] sq_ff  [LANES];
   logic        va_ff, vb_ff;
   logic [31:0] k_a_ff, l_a_ff, k_b_ff, l_b_ff;
   acc_type     acc_a_ff [LANES];
   acc_type     acc_b_ff [LANES];
   logic [31:0] magb_ff  [LANES];
   logic        sgn_a_ff [LANES];
   logic        sgn_b_ff [LANES];
   logic [SUMSQ_W-1:0] s_ff;

   always_comb begin
      mag_in[0] = req_disp_x[31] ? 32'(-req_disp_x) : req_disp_x;
      mag_in[1] = req_disp_y[31] ? 32'(-req_disp_y) : req_disp_y;
      mag_in[2] = req_disp_z[31] ? 32'(-req_disp_z) : req_disp_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= start;
         vb_ff <= va_ff;
      end
      k_a_ff <= req_force_constant;
      l_a_ff <= req_rest_length;
      acc_a_ff[0] <= req_acc_in_x;
      acc_a_ff[1] <= req_acc_in_y;
      acc_a_ff[2] <= req_acc_in_z;
      sgn_a_ff[0] <= req_disp_x[31];
      sgn_a_ff[1] <= req_disp_y[31];
      sgn_a_ff[2] <= req_disp_z[31];
      for (int i = 0; i < LANES; i++) begin
         mag_ff[i]   <= mag_in[i];
         sq_ff[i]    <= 64'(mag_in[i]) * 64'(mag_in[i]);
         magb_ff[i]  <= mag_ff[i];
         acc_b_ff[i] <= acc_a_ff[i];
         sgn_b_ff[i] <= sgn_a_ff[i];
      end
      k_b_ff <= k_a_ff;
      l_b_ff <= l_a_ff;
      s_ff <= SUMSQ_W'(sq_ff[0]) + SUMSQ_W'(sq_ff[1]) + SUMSQ_W'(sq_ff[2]);
   end

   // Square root; side data delayed alongside.
   logic              vr;
   logic [ROOT_W-1:0] d;
   logic              vs_ff;
   logic [SUMSQ_W-1:0] s_c_ff;
   always_ff @(posedge clock) begin
      if (reset) vs_ff <= 1'b0;
      else       vs_ff <= vb_ff;
      s_c_ff <= s_ff;
   end

   hbef_isqrt u_sqrt (
      .clock(clock), .reset(reset), .in_valid(vs_ff), .radicand(s_c_ff),
      .out_valid(vr), .root(d)
   );

   logic [31:0] k_d  [SQ+2];
   logic [31:0] l_d  [SQ+2];
   logic [31:0] m_d  [LANES][SQ+4];
   logic        g_d  [LANES][SQ+6];
   acc_type     a_d  [LANES][SQ+6];
   always_comb begin
      k_d[0] = k_b_ff;
      l_d[0] = l_b_ff;
      for (int i = 0; i < LANES; i++) begin
         m_d[i][0] = magb_ff[i];
         g_d[i][0] = sgn_b_ff[i];
         a_d[i][0] = acc_b_ff[i];
      end
   end
   for (genvar t = 0; t < SQ + 1; t++) begin : g_side
      always_ff @(posedge clock) begin
         k_d[t+1] <= k_d[t];
         l_d[t+1] <= l_d[t];
      end
   end
   for (genvar t = 0; t < SQ + 3; t++) begin : g_side_m
      always_ff @(posedge clock) begin
         for (int i = 0; i < LANES; i++)
            m_d[i][t+1] <= m_d[i][t];
      end
   end
   for (genvar t = 0; t < SQ + 5; t++) begin : g_side_ga
      always_ff @(posedge clock) begin
         for (int i = 0; i < LANES; i++) begin
            g_d[i][t+1] <= g_d[i][t];
            a_d[i][t+1] <= a_d[i][t];
         end
      end
   end

   // Stage C: deviation.
   logic        vc_ff;
   logic [ROOT_W-1:0] emag_ff, d_c_ff;
   logic        eneg_c_ff;
   logic [31:0] k_c_ff;
   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else       vc_ff <= vr;
      eneg_c_ff <= d < ROOT_W'(l_d[SQ+1]);
      emag_ff   <= (d < ROOT_W'(l_d[SQ+1])) ? ROOT_W'(ROOT_W'(l_d[SQ+1]) - d)
                                            : ROOT_W'(d - ROOT_W'(l_d[SQ+1]));
      d_c_ff    <= d;
      k_c_ff    <= k_d[SQ+1];
   end

   // Stage D: e^2 and k*e. Stage E: partial products of k*e^2 and (k*e)*|c|.
   // Stage F: add the partial products.
   logic        vd_ff, ve_ff, vf_ff;
   logic [65:0] e2_ff;
   logic [64:0] ke_ff;
   logic [31:0] k_dd_ff;
   logic [ROOT_W-1:0] d_d_ff, d_e_ff, d_f_ff;
   logic        eneg_d_ff, eneg_e_ff, eneg_f_ff;
   logic [64:0] ke2_lo_ff, ke2_hi_ff;
   logic [97:0] ke2_ff;
   logic [63:0] pc_lo_ff [LANES];
   logic [64:0] pc_hi_ff [LANES];
   logic [96:0] pc_ff    [LANES];
   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
      end else begin
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
      end
      e2_ff     <= 66'(emag_ff) * 66'(emag_ff);
      ke_ff     <= 65'(emag_ff) * 65'(k_c_ff);
      k_dd_ff   <= k_c_ff;
      d_d_ff    <= d_c_ff;
      eneg_d_ff <= eneg_c_ff;
      d_e_ff    <= d_d_ff;
      eneg_e_ff <= eneg_d_ff;
      d_f_ff    <= d_e_ff;
      eneg_f_ff <= eneg_e_ff;
      ke2_lo_ff <= 65'(e2_ff[32:0]) * 65'(k_dd_ff);
      ke2_hi_ff <= 65'(e2_ff[65:33]) * 65'(k_dd_ff);
      ke2_ff    <= (98'(ke2_hi_ff) << 33) + 98'(ke2_lo_ff);
      for (int i = 0; i < LANES; i++) begin
         pc_lo_ff[i] <= 64'(ke_ff[31:0]) * 64'(m_d[i][SQ+3]);
         pc_hi_ff[i] <= 65'(ke_ff[64:32]) * 65'(m_d[i][SQ+3]);
         pc_ff[i]    <= (97'(pc_hi_ff[i]) << 32) + 97'(pc_lo_ff[i]);
      end
   end

   // Energy with truncation to FRAC_BITS and saturation.
   logic [63:0] en_e;
   logic        en_sat_e;
   always_comb begin
      en_sat_e = (ke2_ff >> (FRAC_BITS + 64)) != '0;
      en_e     = en_sat_e ? '1 : 64'(ke2_ff >> FRAC_BITS);
   end

   logic [63:0] en_d  [DLY_ENERGY+1];
   logic        es_d  [DLY_ENERGY+1];
   logic        v_d   [DLY_ENERGY+1];
   always_comb begin
      en_d[0] = en_e;
      es_d[0] = en_sat_e;
      v_d[0]  = vf_ff;
   end
   for (genvar t = 0; t < DLY_ENERGY; t++) begin : g_en
      always_ff @(posedge clock) begin
         if (reset) v_d[t+1] <= 1'b0;
         else       v_d[t+1] <= v_d[t];
         en_d[t+1] <= en_d[t];
         es_d[t+1] <= es_d[t];
      end
   end

   // Force lanes.
   acc_type      lane_out [LANES];
   logic         lane_sat [LANES];
   lane_ctl_type ctl;
   logic [DEN_W-1:0] den;
   always_comb begin
      ctl.zero = d_f_ff == '0;
      ctl.eneg = eneg_f_ff;
      den = DEN_W'(d_f_ff) << FRAC_BITS;
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      hbef_lane u_lane (
         .clock(clock),
         .numer({NUM_W'(pc_ff[i]) << 1}),
         .denom(den),
         .sign_neg(eneg_f_ff != g_d[i][SQ+5] ? 1'b1 : 1'b0),
         .ctl(ctl),
         .acc_in(a_d[i][SQ+5]),
         .acc_out(lane_out[i]),
         .sat(lane_sat[i])
      );
   end

   // Side data above reaches stage F at index SQ+5; keep it aligned there.
   logic zero_out;
   logic zn_d [DLY_ENERGY+1];
   always_comb zn_d[0] = ctl.zero;
   for (genvar t = 0; t < DLY_ENERGY; t++) begin : g_zn
      always_ff @(posedge clock) zn_d[t+1] <= zn_d[t];
   end
   assign zero_out = zn_d[DLY_ENERGY];

   // Merge lanes with energy.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= v_d[DLY_ENERGY];
      rsp_energy    <= en_d[DLY_ENERGY];
      rsp_acc_out_x <= lane_out[0];
      rsp_acc_out_y <= lane_out[1];
      rsp_acc_out_z <= lane_out[2];
      rsp_zero_norm <= zero_out;
      rsp_saturated <= es_d[DLY_ENERGY] | lane_sat[0] | lane_sat[1] | lane_sat[2];
   end
endmodule

FILE: hdl/hbef_checker.sv
module hbef_assertions (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid
);
   localparam int LATENCY = 91;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_idle_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
   a_valid_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(rsp_valid))
      else $error("result strobe unknown");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("result missing after fixed latency");
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching beat");
endmodule

bind harmonic_bond_energy_force_core hbef_assertions u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid)
);
